// ----- rtl/core/mcfe_pkg.sv -----
// ----------------------------------------------------------------------------
// mcfe_pkg
// Shared types and constants of the motor command frame encoder.
// ----------------------------------------------------------------------------
package mcfe_pkg;

  localparam int ID_W     = 11;
  localparam int VAL_W    = 32;
  localparam int LIM_W    = 31;
  localparam int SPAN_W   = 32;
  localparam int QUO_W    = 16;
  localparam int NUM_W    = SPAN_W + QUO_W;
  localparam int POS_BITS = 16;
  localparam int CTL_BITS = 12;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_LAT  = QUO_W;
  localparam int PIPE_LAT = DIV_LAT + 2;

  localparam logic [ID_W-1:0] CMD_ID_BITS = 11'h070;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_D   = 3'd1,
    REG_POSITION = 3'd2,
    REG_VELOCITY = 3'd3,
    REG_CURRENT  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LIM_W-1:0] gain_p;
    logic [LIM_W-1:0] gain_d;
    logic [LIM_W-1:0] position;
    logic [LIM_W-1:0] velocity;
    logic [LIM_W-1:0] current;
  } lim_t;

  typedef struct packed {
    logic            err;
    logic [ID_W-1:0] id;
  } side_t;

endpackage

// ----- rtl/core/mcfe_cfg.sv -----
// ----------------------------------------------------------------------------
// mcfe_cfg
// Limit register file written through the configuration channel.
// ----------------------------------------------------------------------------
module mcfe_cfg
  import mcfe_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  output lim_t                 lim
);

  localparam logic [LIM_W-1:0] ONE = LIM_W'(1) << FRAC_BITS;

  lim_t lim_r;

  assign cfg_ready = 1'b1;
  assign lim       = lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= '{gain_p: ONE, gain_d: ONE, position: ONE, velocity: ONE, current: ONE};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_P:   lim_r.gain_p   <= cfg_data[LIM_W-1:0];
        REG_GAIN_D:   lim_r.gain_d   <= cfg_data[LIM_W-1:0];
        REG_POSITION: lim_r.position <= cfg_data[LIM_W-1:0];
        REG_VELOCITY: lim_r.velocity <= cfg_data[LIM_W-1:0];
        REG_CURRENT:  lim_r.current  <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/mcfe_prep.sv -----
// ----------------------------------------------------------------------------
// mcfe_prep
// Two stages: offset and clamp into the range, then scale to the dividend.
// ----------------------------------------------------------------------------
module mcfe_prep
  import mcfe_pkg::*;
#(
  parameter int QBITS = 12,
  parameter bit SYM   = 1'b1
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [VAL_W-1:0] x,
  input  logic [LIM_W-1:0]        lim,
  output logic [NUM_W-1:0]        num,
  output logic [SPAN_W-1:0]       span
);

  logic signed [VAL_W+1:0] off;
  logic signed [VAL_W+1:0] span_s;
  logic [SPAN_W-1:0]       n_nxt;
  logic [SPAN_W-1:0]       n_r;
  logic [NUM_W-1:0]        n_ext;
  logic [NUM_W-1:0]        num_r;

  assign span   = SYM ? {lim, 1'b0} : {1'b0, lim};
  assign off    = (VAL_W+2)'(x) + (SYM ? $signed({3'b000, lim}) : '0);
  assign span_s = $signed({2'b00, span});

  always_comb begin
    if (off < 0) begin
      n_nxt = '0;
    end else if (off > span_s) begin
      n_nxt = span;
    end else begin
      n_nxt = off[SPAN_W-1:0];
    end
  end

  assign n_ext = {{QUO_W{1'b0}}, n_r};
  assign num   = num_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_nxt;
      num_r <= (n_ext << QBITS) - n_ext;
    end
  end

endmodule

// ----- rtl/core/mcfe_div.sv -----
// ----------------------------------------------------------------------------
// mcfe_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mcfe_div
  import mcfe_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [SPAN_W-1:0] span,
  output logic [QUO_W-1:0]  quo
);

  logic [NUM_W-1:0] rem_r [1:QUO_W-1];
  logic [QUO_W-1:0] quo_r [1:QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [NUM_W-1:0] cur_rem;
    logic [QUO_W-1:0] cur_quo;
    logic [NUM_W-1:0] dsr;
    logic             ge;
    if (k == 0) begin : g_first
      assign cur_rem = num;
      assign cur_quo = '0;
    end else begin : g_next
      assign cur_rem = rem_r[k];
      assign cur_quo = quo_r[k];
    end
    assign dsr = {{QUO_W{1'b0}}, span} << (QUO_W - 1 - k);
    assign ge  = cur_rem >= dsr;
    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k+1] <= {cur_quo[QUO_W-2:0], ge};
      end
    end
    if (k < QUO_W-1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? cur_rem - dsr : cur_rem;
        end
      end
    end
  end

  assign quo = quo_r[QUO_W];

endmodule

// ----- rtl/core/mit_command_frame_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// mit_command_frame_encoder_unit
// Packs one motor command into an eight-byte command frame.
// ----------------------------------------------------------------------------
// Usage: a command transaction on the in_ channel (valid/stall) carries the
// motor id, two gains and the position, velocity and current targets. Each
// command gives exactly one out_ transaction with frame_id, payload and
// limit_error, in order. The user must write the five limits through the cfg_
// channel (always ready) only while no command is in flight (not enforced).
// The pipeline has two stages of offset, clamp and scaling, then a
// 16-stage divider that yields one quotient bit per stage. A new command
// is taken every cycle unless in_stall is high, so throughput is one per cycle.
// Reset clears all valid bits and sets every limit to 1.0. When the
// receiver stalls with a result waiting, the whole pipeline holds and
// in_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module mit_command_frame_encoder_unit
  import mcfe_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ID_W-1:0]         in_motor_id,
  input  logic signed [VAL_W-1:0] in_gain_p,
  input  logic signed [VAL_W-1:0] in_gain_d,
  input  logic signed [VAL_W-1:0] in_target_position,
  input  logic signed [VAL_W-1:0] in_target_velocity,
  input  logic signed [VAL_W-1:0] in_target_current,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ID_W-1:0]         out_frame_id,
  output logic [63:0]             out_payload,
  output logic                    out_limit_error,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [VAL_W-1:0]        cfg_data
);

  lim_t              lim;
  logic              en;
  logic              valid_r [0:PIPE_LAT-1];
  side_t             side_r  [0:PIPE_LAT-1];
  side_t             side_nxt;
  logic [NUM_W-1:0]  num  [0:4];
  logic [SPAN_W-1:0] span [0:4];
  logic [QUO_W-1:0]  quo  [0:4];

  mcfe_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .lim
  );

  assign en       = !valid_r[PIPE_LAT-1] || !out_stall;
  assign in_stall = !en;

  assign side_nxt.id  = in_motor_id | CMD_ID_BITS;
  assign side_nxt.err = (lim.gain_p == '0) || (lim.gain_d == '0) ||
                        (lim.position == '0) || (lim.velocity == '0) ||
                        (lim.current == '0);

  mcfe_prep #(.QBITS(POS_BITS), .SYM(1'b1)) u_prep_pos (
    .clk, .en, .x(in_target_position), .lim(lim.position),
    .num(num[0]), .span(span[0])
  );
  mcfe_prep #(.QBITS(CTL_BITS), .SYM(1'b1)) u_prep_vel (
    .clk, .en, .x(in_target_velocity), .lim(lim.velocity),
    .num(num[1]), .span(span[1])
  );
  mcfe_prep #(.QBITS(CTL_BITS), .SYM(1'b0)) u_prep_kp (
    .clk, .en, .x(in_gain_p), .lim(lim.gain_p),
    .num(num[2]), .span(span[2])
  );
  mcfe_prep #(.QBITS(CTL_BITS), .SYM(1'b0)) u_prep_kd (
    .clk, .en, .x(in_gain_d), .lim(lim.gain_d),
    .num(num[3]), .span(span[3])
  );
  mcfe_prep #(.QBITS(CTL_BITS), .SYM(1'b1)) u_prep_cur (
    .clk, .en, .x(in_target_current), .lim(lim.current),
    .num(num[4]), .span(span[4])
  );

  for (genvar l = 0; l < 5; l++) begin : g_lane
    mcfe_div u_div (
      .clk, .en, .num(num[l]), .span(span[l]), .quo(quo[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < PIPE_LAT; s++) valid_r[s] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int s = 1; s < PIPE_LAT; s++) valid_r[s] <= valid_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int s = 1; s < PIPE_LAT; s++) side_r[s] <= side_r[s-1];
    end
  end

  assign out_valid       = valid_r[PIPE_LAT-1];
  assign out_frame_id    = side_r[PIPE_LAT-1].id;
  assign out_limit_error = side_r[PIPE_LAT-1].err;
  assign out_payload     = side_r[PIPE_LAT-1].err ? 64'd0 :
                           {quo[0], quo[1][CTL_BITS-1:0], quo[2][CTL_BITS-1:0],
                            quo[3][CTL_BITS-1:0], quo[4][CTL_BITS-1:0]};

endmodule

// ----- verif/mit_command_frame_encoder_unit_tb.sv -----
// ----------------------------------------------------------------------------
// mit_command_frame_encoder_unit_tb
// Self-checking bench for the motor command frame encoder: directed commands
// and zero-limit cases, then random commands under several idle/stall mixes
// and limit settings, checked by typed frames or an in-bench quantizer/packer.
// ----------------------------------------------------------------------------
module mit_command_frame_encoder_unit_tb;
  import mcfe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = PIPE_LAT + 8;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [VAL_W-1:0] kp, kd, pos, vel, cur;
  } command_t;

  typedef struct {
    logic [ID_W-1:0] frame_id;
    logic [63:0]     payload;
    logic            limit_error;
  } frame_t;

  typedef struct {
    command_t cmd;
    bit       typed;
    frame_t   frame;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [ID_W-1:0] in_motor_id = '0;
  logic signed [VAL_W-1:0] in_gain_p = '0, in_gain_d = '0, in_target_position = '0;
  logic signed [VAL_W-1:0] in_target_velocity = '0, in_target_current = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [ID_W-1:0] out_frame_id;
  logic [63:0] out_payload;
  logic out_limit_error;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0] cfg_data = '0;

  mit_command_frame_encoder_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [LIM_W-1:0] lim_kp, lim_kd, lim_pos, lim_vel, lim_cur;
  frame_t expected_frames[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;

  function automatic logic [15:0] quantize(logic [VAL_W-1:0] x, logic [LIM_W-1:0] lim,
                                           bit symmetric, int bits);
    longint sx, lo, num;
    longint unsigned span, n;
    sx = longint'(signed'(x));
    lo = symmetric ? -longint'(lim) : 0;
    span = symmetric ? 2 * longint'(lim) : longint'(lim);
    num = sx - lo;
    if (num < 0) num = 0;
    n = num;
    if (n > span) n = span;
    return 16'((n * ((64'd1 << bits) - 1)) / span);
  endfunction

  function automatic frame_t encode_frame(command_t c);
    frame_t f;
    f.frame_id = c.id | CMD_ID_BITS;
    f.payload = '0;
    f.limit_error = (lim_kp == 0) || (lim_kd == 0) || (lim_pos == 0) ||
                    (lim_vel == 0) || (lim_cur == 0);
    if (!f.limit_error)
      f.payload = {quantize(c.pos, lim_pos, 1, POS_BITS),
                   12'(quantize(c.vel, lim_vel, 1, CTL_BITS)),
                   12'(quantize(c.kp, lim_kp, 0, CTL_BITS)),
                   12'(quantize(c.kd, lim_kd, 0, CTL_BITS)),
                   12'(quantize(c.cur, lim_cur, 1, CTL_BITS))};
    return f;
  endfunction

  task automatic write_limit(reg_idx_t idx, logic [VAL_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GAIN_P:   lim_kp = value[LIM_W-1:0];
      REG_GAIN_D:   lim_kd = value[LIM_W-1:0];
      REG_POSITION: lim_pos = value[LIM_W-1:0];
      REG_VELOCITY: lim_vel = value[LIM_W-1:0];
      REG_CURRENT:  lim_cur = value[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_limits(logic [VAL_W-1:0] kp, logic [VAL_W-1:0] kd,
                            logic [VAL_W-1:0] pos, logic [VAL_W-1:0] vel,
                            logic [VAL_W-1:0] cur);
    write_limit(REG_GAIN_P, kp);
    write_limit(REG_GAIN_D, kd);
    write_limit(REG_POSITION, pos);
    write_limit(REG_VELOCITY, vel);
    write_limit(REG_CURRENT, cur);
  endtask

  // entered at a falling edge, returns at a falling edge
  task automatic send_command(command_t c, bit typed, frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_motor_id <= c.id;
    in_gain_p <= c.kp;
    in_gain_d <= c.kd;
    in_target_position <= c.pos;
    in_target_velocity <= c.vel;
    in_target_current <= c.cur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_frames.push_back(typed ? f : encode_frame(c));
    @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] random_value(logic [LIM_W-1:0] lim);
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($urandom_range(lim));
      2: return -32'($urandom_range(lim));
      3: return lim + 32'($urandom_range(3)) - 2;
      4: return -lim - 32'($urandom_range(3)) + 2;
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic command_t random_command();
    command_t c;
    c.id = ID_W'($urandom);
    c.kp = random_value(lim_kp);
    c.kd = random_value(lim_kd);
    c.pos = random_value(lim_pos);
    c.vel = random_value(lim_vel);
    c.cur = random_value(lim_cur);
    return c;
  endfunction

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected frame transaction, frame_id %h", out_frame_id);
        errors = errors + 1;
      end else begin
        frame_t e;
        e = expected_frames.pop_front();
        if (out_frame_id !== e.frame_id) begin
          $error("frame_id expected %h actual %h", e.frame_id, out_frame_id);
          errors = errors + 1;
        end
        if (out_payload !== e.payload) begin
          $error("payload expected %h actual %h", e.payload, out_payload);
          errors = errors + 1;
        end
        if (out_limit_error !== e.limit_error) begin
          $error("limit_error expected %b actual %b", e.limit_error, out_limit_error);
          errors = errors + 1;
        end
      end
    end
  end

  row_t directed[$];

  function automatic row_t mk(logic [ID_W-1:0] id, logic [VAL_W-1:0] kp, logic [VAL_W-1:0] kd,
                              logic [VAL_W-1:0] pos, logic [VAL_W-1:0] vel,
                              logic [VAL_W-1:0] cur, bit typed, logic [63:0] pl, bit er);
    row_t r;
    r.cmd = '{id, kp, kd, pos, vel, cur};
    r.typed = typed;
    r.frame = '{id | CMD_ID_BITS, pl, er};
    return r;
  endfunction

  initial begin
    frame_t none;
    command_t c;
    lim_kp = 31'h10000; lim_kd = 31'h10000; lim_pos = 31'h10000;
    lim_vel = 31'h10000; lim_cur = 31'h10000;
    // reset limits are 1.0: zeros give mid scale, gains at zero
    directed.push_back(mk(11'h000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1,
                          64'h7fff_7ff_000_000_7ff, 0));
    directed.push_back(mk(11'h7ff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 1, 64'hffff_fff_fff_fff_fff, 0));
    directed.push_back(mk(11'h00f, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h80000000, 1, 64'h0, 0));
    directed.push_back(mk(11'h555, 32'hffffffff, 32'h10000, 32'h10000, 32'hffff0000,
                          32'h10000, 1, 64'hffff_000_000_fff_fff, 0));
    directed.push_back(mk(11'h2aa, 32'h8000, 32'h8000, 32'h8000, 32'h8000, 32'h8000, 0, 0, 0));
    directed.push_back(mk(11'h070, 32'h5555aaaa, 32'haaaa5555, 32'hffff8000, 32'h00007fff,
                          32'hfffeffff, 0, 0, 0));
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    foreach (directed[i]) send_command(directed[i].cmd, directed[i].typed, directed[i].frame);
    wait_drained();

    // zero limit on each register in turn gives an error frame
    for (int r = 0; r < 5; r++) begin
      write_limit(reg_idx_t'(r), 32'h0);
      c = '{11'h123, 32'h100, 32'h100, 32'h100, 32'h100, 32'h100};
      send_command(c, 1, '{11'h173, 64'h0, 1'b1});
      wait_drained();
      write_limit(reg_idx_t'(r), 32'h10000);
    end
    // out-of-range index and upper data bit are ignored
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= 3'd7;
    cfg_data <= 32'h0;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    set_limits(32'h80000001, 32'h80000001, 32'h80000001, 32'h80000001, 32'h80000001);
    send_command('{11'h001, 32'h1, 32'h0, 32'h0, 32'h1, 32'hffffffff}, 0, none);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 60; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 60; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      case (ph)
        0: set_limits(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
        1: set_limits(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        2: set_limits(32'h1, 32'h1, 32'h1, 32'h1, 32'h1);
        3: set_limits(32'h500000, 32'h1000, 32'h3243f, 32'h2d0000, 32'h1e0000);
        5: set_limits(32'h7fffffff, 32'h1, 32'h7fffffff, 32'h1, 32'h12345);
        default: set_limits($urandom_range(1 << 24, 1), $urandom_range(1 << 24, 1),
                            $urandom, $urandom_range(1 << 20, 1), $urandom_range(1 << 26, 1));
      endcase
      if (ph == 0) hold_off = 200;
      repeat (200) send_command(random_command(), 0, none);
      wait_drained();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
